>>> hdl/bdtw_pkg.sv
// Package with the widths, direction codes and saturating add of the banded DTW cost update.
`default_nettype none

package bdtw_pkg;

	localparam int MAX_COLS   = 1024;
	localparam int COL_BITS   = $clog2(MAX_COLS);
	localparam int BAND_BITS  = COL_BITS + 1;
	localparam int DIST_BITS  = 16;
	localparam int COST_BITS  = 32;
	localparam int W_BITS     = 8;
	localparam int W_FRAC     = 6;
	localparam int PROD_BITS  = DIST_BITS + W_BITS;
	localparam int INC_BITS   = PROD_BITS - W_FRAC;

	localparam logic [W_BITS-1:0]    W_RESET  = W_BITS'(128);
	localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

	// Step that led to a cell.
	typedef enum logic [1:0] {
		DIR_NONE  = 2'd0,
		DIR_DIAG  = 2'd1,
		DIR_VERT  = 2'd2,
		DIR_HORIZ = 2'd3
	} dir_t;

	// Add two costs and clamp at the largest cost.
	function automatic logic [COST_BITS-1:0] sat_add(input logic [COST_BITS-1:0] a,
			input logic [COST_BITS-1:0] b);
		logic [COST_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COST_BITS] ? COST_MAX : s[COST_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

>>> hdl/banded_dtw_cost_update.sv
// Banded dynamic-time-warping cost update with a weighted diagonal step and a row buffer.
//
// Usage: local distance cells of a banded DTW matrix enter on the s_ channel in row-major
// order, columns rising inside a row; one beat is one cell. Each cell leaves as one beat
// on the m_ channel with its accumulated cost, winning direction and column, in order.
// The previous row's costs sit in a 1024-entry row buffer with one write and two read
// ports; the cell read-modify-writes its own column and also reads the column to its left,
// used at a row start. A write that overlaps a read of the same entry is forwarded.
// Each accepted beat passes the compute-stage registers and then the output register.
// Throughput: one cell per cycle while the receiver does not stall, set by the horizontal
// add-compare loop through the left-cost register in the compute stage.
// When the receiver stalls, the finished beat holds in the output register; one more cell
// may enter and wait in the compute stage, after which s_tready falls.
// The diagonal weight (unsigned Q2.6) is written through cfg_we/cfg_data; the user must
// write it only while idle, which the block itself does not enforce.
// Reset clears the pipeline, the band and carry registers and sets the weight to 2.0.
// The row buffer is not cleared; each entry is written before its read value is used.
`default_nettype none

module banded_dtw_cost_update import bdtw_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// distance[15:0], column[25:16], band_start[35:26], band_stop[46:36], zero[47]
	input  wire logic [47:0] s_tdata,
	// first_row[0]
	input  wire logic        s_tuser,
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// cost[31:0], direction[33:32], out_column[43:34], zero[47:44]
	output logic [47:0]      m_tdata,
	// cost_valid[0]
	output logic             m_tuser,
	output logic             m_tlast
);

	// Input field split.
	logic [DIST_BITS-1:0] in_dist;
	logic [COL_BITS-1:0]  in_col;
	logic [COL_BITS-1:0]  in_bstart;
	logic [BAND_BITS-1:0] in_bstop;
	logic                 in_accept;

	assign in_dist   = s_tdata[DIST_BITS-1:0];
	assign in_col    = s_tdata[DIST_BITS +: COL_BITS];
	assign in_bstart = s_tdata[DIST_BITS+COL_BITS +: COL_BITS];
	assign in_bstop  = s_tdata[DIST_BITS+2*COL_BITS +: BAND_BITS];

	// Registers.
	logic [W_BITS-1:0]    weight_q;
	logic                 v_s1;
	logic [DIST_BITS-1:0] dist_s1;
	logic [INC_BITS-1:0]  inc_s1;
	logic [COL_BITS-1:0]  col_s1;
	logic [COL_BITS-1:0]  bstart_s1;
	logic [BAND_BITS-1:0] bstop_s1;
	logic                 first_s1;
	logic                 last_s1;
	logic                 fwd_up_s1;
	logic                 fwd_left_s1;
	logic [COST_BITS-1:0] rd_up_s1;
	logic [COST_BITS-1:0] rd_left_s1;
	logic [BAND_BITS-1:0] prev_bs_q, prev_be_q, cur_bs_q, cur_be_q;
	logic [COST_BITS-1:0] left_q, diag_q;
	logic                 out_v_q;
	logic [COST_BITS-1:0] out_cost_q;
	dir_t                 out_dir_q;
	logic                 out_ok_q;
	logic [COL_BITS-1:0]  out_col_q;
	logic                 out_last_q;
	logic [COST_BITS-1:0] row_mem [MAX_COLS];

	// Handshake: the compute stage moves on when the output register is free or drains.
	logic fire_s1;
	assign fire_s1   = v_s1 && (!out_v_q || m_tready);
	assign s_tready  = !v_s1 || fire_s1;
	assign in_accept = s_tvalid && s_tready;

	// Diagonal increment, registered before the add-compare stage.
	logic [PROD_BITS-1:0] prod;
	assign prod = PROD_BITS'(in_dist) * PROD_BITS'(weight_q);

	// Compute stage: band bookkeeping at a row start.
	logic                 row_start;
	logic [BAND_BITS-1:0] col_x;
	logic [BAND_BITS-1:0] pbs, pbe, cbs, cbe;
	logic [COST_BITS-1:0] up, left_rd, diag_prev, straight, diag_inc;

	assign row_start = (col_s1 == bstart_s1);
	assign col_x     = {1'b0, col_s1};
	assign pbs       = row_start ? cur_bs_q : prev_bs_q;
	assign pbe       = row_start ? cur_be_q : prev_be_q;
	assign cbs       = row_start ? {1'b0, bstart_s1} : cur_bs_q;
	assign cbe       = row_start ? bstop_s1 : cur_be_q;
	assign up        = fwd_up_s1 ? left_q : rd_up_s1;
	assign left_rd   = fwd_left_s1 ? left_q : rd_left_s1;
	assign straight  = COST_BITS'(dist_s1);
	assign diag_inc  = COST_BITS'(inc_s1);

	always_comb begin
		if (!row_start) begin
			diag_prev = diag_q;
		end else if (col_s1 == '0) begin
			diag_prev = '0;
		end else begin
			diag_prev = left_rd;
		end
	end

	// Compute stage: least of the candidates, earlier one winning a tie.
	logic [COST_BITS-1:0] c_diag, c_vert, c_horiz, cost, stored;
	dir_t                 dir;
	logic                 have;

	assign c_diag  = sat_add(diag_prev, diag_inc);
	assign c_vert  = sat_add(up, straight);
	assign c_horiz = sat_add(left_q, straight);

	always_comb begin
		cost = '0;
		dir  = DIR_NONE;
		have = 1'b0;
		if (first_s1) begin
			if (col_x > cbs) begin
				cost = c_horiz;
				dir  = DIR_HORIZ;
			end else begin
				cost = straight;
			end
			have = 1'b1;
		end else begin
			if (col_x > pbs && col_x <= pbe) begin
				cost = c_diag;
				dir  = DIR_DIAG;
				have = 1'b1;
			end
			if (col_x >= pbs && col_x < pbe) begin
				if (!have || c_vert < cost) begin
					cost = c_vert;
					dir  = DIR_VERT;
				end
				have = 1'b1;
			end
			if (col_x > cbs) begin
				if (!have || c_horiz < cost) begin
					cost = c_horiz;
					dir  = DIR_HORIZ;
				end
				have = 1'b1;
			end
		end
		stored = have ? cost : COST_MAX;
	end

	// Row buffer: two registered reads at accept, one write when a cell completes.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			rd_up_s1   <= row_mem[in_col];
			rd_left_s1 <= row_mem[in_col - COL_BITS'(1)];
		end
		if (fire_s1) begin
			row_mem[col_s1] <= stored;
		end
	end

	// Input stage payload and forwarding flags for a write landing in the read cycle.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			dist_s1     <= in_dist;
			inc_s1      <= prod[PROD_BITS-1:W_FRAC];
			col_s1      <= in_col;
			bstart_s1   <= in_bstart;
			bstop_s1    <= in_bstop;
			first_s1    <= s_tuser;
			last_s1     <= s_tlast;
			fwd_up_s1   <= fire_s1 && (col_s1 == in_col);
			fwd_left_s1 <= fire_s1 && (col_s1 == in_col - COL_BITS'(1));
		end
	end

	// Control, band and carry state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q  <= W_RESET;
			v_s1      <= 1'b0;
			out_v_q   <= 1'b0;
			prev_bs_q <= '0;
			prev_be_q <= '0;
			cur_bs_q  <= '0;
			cur_be_q  <= '0;
			left_q    <= '0;
			diag_q    <= '0;
		end else begin
			if (cfg_we) begin
				weight_q <= cfg_data;
			end
			if (in_accept) begin
				v_s1 <= 1'b1;
			end else if (fire_s1) begin
				v_s1 <= 1'b0;
			end
			if (fire_s1) begin
				out_v_q   <= 1'b1;
				prev_bs_q <= pbs;
				prev_be_q <= pbe;
				cur_bs_q  <= cbs;
				cur_be_q  <= cbe;
				left_q    <= stored;
				diag_q    <= up;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_cost_q <= have ? cost : '0;
			out_dir_q  <= dir;
			out_ok_q   <= have;
			out_col_q  <= col_s1;
			out_last_q <= last_s1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {4'b0, out_col_q, out_dir_q, out_cost_q};
	assign m_tuser  = out_ok_q;
	assign m_tlast  = out_last_q;

`ifndef ASSERT_OFF
	// Input is refused only while a cell waits behind a full output register.
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v_s1 && out_v_q && !m_tready))
		else $error("input refused without a stall");

	// A cell in the compute stage is not lost while the output stalls.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && out_v_q && !m_tready) |=> v_s1)
		else $error("compute stage dropped a stalled cell");

	// A cell without a predecessor reports zero cost and no direction.
	a_no_pred: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (out_cost_q == '0 && out_dir_q == DIR_NONE))
		else $error("cell without predecessor carries a cost");
`endif

endmodule

`default_nettype wire
